// File: design/depth_pixel_backprojection_core_macros.svh
// Assertion macros used by the checker file dpb_checker.sv.
`ifndef DEPTH_PIXEL_BACKPROJECTION_CORE_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_CORE_MACROS_SVH

// Check on every rising edge outside reset.
`define DPB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every rising edge, reset included.
`define DPB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: design/dpb_pkg.sv
`timescale 1ns / 1ps
package dpb_pkg;

    localparam int DEPTH_W        = 16;
    localparam int CFG_W          = 16;
    localparam int COLOR_W        = 8;
    localparam int PIX_FRAC       = 4;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COORD_BITS_DEF = 12;
    localparam int PDATA_W        = 32;
    localparam int PADDR_W        = 5;

    typedef enum logic [PADDR_W-3:0] {
        REG_DEPTH_SCALE = 0,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_FOCAL_X,
        REG_FOCAL_Y
    } reg_idx_t;

    localparam logic [CFG_W-1:0] DEPTH_SCALE_RST = 16'd1000;
    localparam logic [CFG_W-1:0] CENTER_X_RST    = 16'd5208;
    localparam logic [CFG_W-1:0] CENTER_Y_RST    = 16'd4056;
    localparam logic [CFG_W-1:0] FOCAL_X_RST     = 16'd8288;
    localparam logic [CFG_W-1:0] FOCAL_Y_RST     = 16'd8304;

endpackage

// File: design/depth_pixel_backprojection_core.sv
`timescale 1ns / 1ps
// Back-projects one RGB-D pixel per word into a 3-D point through a pinhole model:
// z = depth*2^FRAC_BITS/depth_scale, x = (col*16-center_x)*z/focal_x and
// y = (row*16-center_y)*z/focal_y, all truncating, then saturated to Q(COORD_BITS).FRAC_BITS,
// with the colour bytes passed through; a pixel of zero depth yields no output word.
// One word is accepted per clock while the pipeline is not stalled (see below).
// The datapath is built from two chains of one-bit-per-stage restoring dividers:
// DEPTH_W+FRAC_BITS stages for z, then COORD_BITS+FRAC_BITS stages shared in lockstep by x and y.
// The pipeline keeps moving and accepting words while a result waits at the output,
// until a valid word reaches the last divider stage. Registers are written over APB at
// byte address 4*index; write them only while the pipeline is empty.
module depth_pixel_backprojection_core #(
    parameter int  FRAC_BITS   = dpb_pkg::FRAC_BITS_DEF,
    parameter int  COORD_BITS  = dpb_pkg::COORD_BITS_DEF,
    localparam int Z_BITS      = COORD_BITS + FRAC_BITS,
    localparam int IN_W        = dpb_pkg::DEPTH_W + 2 * COORD_BITS + 3 * dpb_pkg::COLOR_W,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = 3 * Z_BITS + 2 + 3 * dpb_pkg::COLOR_W,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpb_pkg::PADDR_W-1:0] paddr,
    input  logic [dpb_pkg::PDATA_W-1:0] pwdata,
    output logic [dpb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // raw_depth, pixel_column, pixel_row, blue_in, green_in, red_in, zero pad
    input  logic [IN_TDATA_W-1:0]       s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // point_x, point_y, point_z, blue_out, green_out, red_out, zero pad
    output logic [OUT_TDATA_W-1:0]      m_tdata
);
    import dpb_pkg::*;

    localparam int ZQ_W   = DEPTH_W + FRAC_BITS;
    localparam int NUM_W  = ((COORD_BITS + PIX_FRAC > CFG_W) ? COORD_BITS + PIX_FRAC : CFG_W) + 1;
    localparam int MAG_W  = NUM_W - 1;
    localparam int PROD_W = MAG_W + ZQ_W;
    localparam int HI_W   = PROD_W - Z_BITS;
    localparam int REM_W  = CFG_W + 1;
    localparam int XY_W   = Z_BITS + 1;
    localparam int RGB_W  = 3 * COLOR_W;

    localparam logic [XY_W-1:0] XY_MAX = {1'b0, {Z_BITS{1'b1}}};
    localparam logic [XY_W-1:0] XY_MIN = {1'b1, {Z_BITS{1'b0}}};

    typedef struct packed {
        logic [1:0][NUM_W-1:0] num;
        logic [RGB_W-1:0]      rgb;
    } zpay_t;

    typedef struct packed {
        logic [1:0]        neg;
        logic [1:0]        ovf;
        logic [Z_BITS-1:0] zs;
        logic [RGB_W-1:0]  rgb;
    } xpay_t;

    // configuration registers
    logic [CFG_W-1:0] depth_scale_reg;
    logic [CFG_W-1:0] center_x_reg;
    logic [CFG_W-1:0] center_y_reg;
    logic [CFG_W-1:0] focal_x_reg;
    logic [CFG_W-1:0] focal_y_reg;
    logic [CFG_W-1:0] scale_nz;
    logic [1:0][CFG_W-1:0] focal_nz;
    reg_idx_t         reg_sel;

    assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_scale_reg <= DEPTH_SCALE_RST;
            center_x_reg    <= CENTER_X_RST;
            center_y_reg    <= CENTER_Y_RST;
            focal_x_reg     <= FOCAL_X_RST;
            focal_y_reg     <= FOCAL_Y_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_DEPTH_SCALE: depth_scale_reg <= pwdata[CFG_W-1:0];
                REG_CENTER_X:    center_x_reg    <= pwdata[CFG_W-1:0];
                REG_CENTER_Y:    center_y_reg    <= pwdata[CFG_W-1:0];
                REG_FOCAL_X:     focal_x_reg     <= pwdata[CFG_W-1:0];
                REG_FOCAL_Y:     focal_y_reg     <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_DEPTH_SCALE: prdata = PDATA_W'(depth_scale_reg);
            REG_CENTER_X:    prdata = PDATA_W'(center_x_reg);
            REG_CENTER_Y:    prdata = PDATA_W'(center_y_reg);
            REG_FOCAL_X:     prdata = PDATA_W'(focal_x_reg);
            REG_FOCAL_Y:     prdata = PDATA_W'(focal_y_reg);
            default:         prdata = '0;
        endcase
    end

    // treat a zero divisor as one
    assign scale_nz    = (depth_scale_reg == '0) ? CFG_W'(1) : depth_scale_reg;
    assign focal_nz[0] = (focal_x_reg == '0) ? CFG_W'(1) : focal_x_reg;
    assign focal_nz[1] = (focal_y_reg == '0) ? CFG_W'(1) : focal_y_reg;

    // pipeline control
    logic en;
    logic out_load;
    logic out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    logic  zv_reg   [0:ZQ_W];
    zpay_t zpay_reg [0:ZQ_W];
    logic [CFG_W-1:0] zrem_reg  [0:ZQ_W];
    logic [CFG_W-1:0] zrem_next [1:ZQ_W];
    logic [ZQ_W-1:0]  zdq_reg   [0:ZQ_W];
    logic [ZQ_W-1:0]  zdq_next  [1:ZQ_W];

    logic                   mv_reg;
    logic [1:0][PROD_W-1:0] mprod_reg;
    logic [1:0][PROD_W-1:0] mprod_next;
    logic [1:0]             mneg_reg;
    logic [Z_BITS-1:0]      mzs_reg;
    logic [Z_BITS-1:0]      z_sat;
    logic [RGB_W-1:0]       mrgb_reg;

    logic  xv_reg   [0:Z_BITS];
    xpay_t xpay_reg [0:Z_BITS];
    logic [1:0][CFG_W-1:0]  xrem_reg  [0:Z_BITS];
    logic [1:0][CFG_W-1:0]  xrem_next [1:Z_BITS];
    logic [1:0][Z_BITS-1:0] xdq_reg   [0:Z_BITS];
    logic [1:0][Z_BITS-1:0] xdq_next  [1:Z_BITS];
    logic [1:0][CFG_W-1:0]  xrem_init;
    logic [1:0]             ovf_next;
    logic [1:0][XY_W-1:0]   xy_out;

    assign out_load = !out_valid_reg || m_tready;
    assign en       = out_load || !xv_reg[Z_BITS];
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // input unpack
    logic [DEPTH_W-1:0]      in_depth;
    logic [COORD_BITS-1:0]   in_col;
    logic [COORD_BITS-1:0]   in_row;
    logic [RGB_W-1:0]        in_rgb;
    logic [1:0][NUM_W-1:0]   in_num;

    assign in_depth  = s_tdata[DEPTH_W-1:0];
    assign in_col    = s_tdata[DEPTH_W +: COORD_BITS];
    assign in_row    = s_tdata[DEPTH_W + COORD_BITS +: COORD_BITS];
    assign in_rgb    = s_tdata[DEPTH_W + 2 * COORD_BITS +: RGB_W];
    assign in_num[0] = NUM_W'({in_col, PIX_FRAC'(0)}) - NUM_W'(center_x_reg);
    assign in_num[1] = NUM_W'({in_row, PIX_FRAC'(0)}) - NUM_W'(center_y_reg);

    // z divider: one quotient bit per stage
    for (genvar k = 1; k <= ZQ_W; k++) begin : g_zdiv
        logic [REM_W-1:0] trial;
        logic             ge;
        assign trial        = {zrem_reg[k-1], zdq_reg[k-1][ZQ_W-1]};
        assign ge           = trial >= {1'b0, scale_nz};
        assign zrem_next[k] = ge ? CFG_W'(trial - {1'b0, scale_nz}) : trial[CFG_W-1:0];
        assign zdq_next[k]  = {zdq_reg[k-1][ZQ_W-2:0], ge};
    end

    // multiply stage
    if (ZQ_W > Z_BITS) begin : g_zsat
        assign z_sat = (|zdq_reg[ZQ_W][ZQ_W-1:Z_BITS]) ? '1 : zdq_reg[ZQ_W][Z_BITS-1:0];
    end else begin : g_zfit
        assign z_sat = zdq_reg[ZQ_W][Z_BITS-1:0];
    end

    for (genvar a = 0; a < 2; a++) begin : g_mul
        logic [NUM_W-1:0] neg_num;
        logic [MAG_W-1:0] mag;
        assign neg_num       = -zpay_reg[ZQ_W].num[a];
        assign mag           = zpay_reg[ZQ_W].num[a][NUM_W-1] ? neg_num[MAG_W-1:0]
                                                              : zpay_reg[ZQ_W].num[a][MAG_W-1:0];
        assign mprod_next[a] = PROD_W'(mag) * PROD_W'(zdq_reg[ZQ_W]);
    end

    // overflow check and x/y dividers
    for (genvar a = 0; a < 2; a++) begin : g_ovf
        logic [HI_W-1:0] hi;
        assign hi           = mprod_reg[a][PROD_W-1:Z_BITS];
        assign ovf_next[a]  = hi >= HI_W'(focal_nz[a]);
        assign xrem_init[a] = hi[CFG_W-1:0];
    end

    for (genvar k = 1; k <= Z_BITS; k++) begin : g_xydiv
        for (genvar a = 0; a < 2; a++) begin : g_axis
            logic [REM_W-1:0] trial;
            logic             ge;
            assign trial           = {xrem_reg[k-1][a], xdq_reg[k-1][a][Z_BITS-1]};
            assign ge              = trial >= {1'b0, focal_nz[a]};
            assign xrem_next[k][a] = ge ? CFG_W'(trial - {1'b0, focal_nz[a]})
                                        : trial[CFG_W-1:0];
            assign xdq_next[k][a]  = {xdq_reg[k-1][a][Z_BITS-2:0], ge};
        end
    end

    // sign and saturation
    for (genvar a = 0; a < 2; a++) begin : g_out
        logic [XY_W-1:0] q;
        assign q         = {1'b0, xdq_reg[Z_BITS][a]};
        assign xy_out[a] = xpay_reg[Z_BITS].ovf[a] ? (xpay_reg[Z_BITS].neg[a] ? XY_MIN : XY_MAX)
                                                   : (xpay_reg[Z_BITS].neg[a] ? -q : q);
    end

    assign out_data_next = OUT_TDATA_W'({xpay_reg[Z_BITS].rgb, xpay_reg[Z_BITS].zs,
                                         xy_out[1], xy_out[0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= ZQ_W; k++) begin
                zv_reg[k] <= 1'b0;
            end
            mv_reg <= 1'b0;
            for (int k = 0; k <= Z_BITS; k++) begin
                xv_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                zv_reg[0] <= s_tvalid && (in_depth != '0);
                for (int k = 1; k <= ZQ_W; k++) begin
                    zv_reg[k] <= zv_reg[k-1];
                end
                mv_reg    <= zv_reg[ZQ_W];
                xv_reg[0] <= mv_reg;
                for (int k = 1; k <= Z_BITS; k++) begin
                    xv_reg[k] <= xv_reg[k-1];
                end
            end
            if (out_load) begin
                out_valid_reg <= xv_reg[Z_BITS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zpay_reg[0].num <= in_num;
            zpay_reg[0].rgb <= in_rgb;
            zrem_reg[0]     <= '0;
            zdq_reg[0]      <= {in_depth, FRAC_BITS'(0)};
            for (int k = 1; k <= ZQ_W; k++) begin
                zpay_reg[k] <= zpay_reg[k-1];
                zrem_reg[k] <= zrem_next[k];
                zdq_reg[k]  <= zdq_next[k];
            end
            mprod_reg   <= mprod_next;
            mneg_reg[0] <= zpay_reg[ZQ_W].num[0][NUM_W-1];
            mneg_reg[1] <= zpay_reg[ZQ_W].num[1][NUM_W-1];
            mzs_reg     <= z_sat;
            mrgb_reg    <= zpay_reg[ZQ_W].rgb;
            xpay_reg[0].neg <= mneg_reg;
            xpay_reg[0].ovf <= ovf_next;
            xpay_reg[0].zs  <= mzs_reg;
            xpay_reg[0].rgb <= mrgb_reg;
            xrem_reg[0]     <= xrem_init;
            xdq_reg[0][0]   <= mprod_reg[0][Z_BITS-1:0];
            xdq_reg[0][1]   <= mprod_reg[1][Z_BITS-1:0];
            for (int k = 1; k <= Z_BITS; k++) begin
                xpay_reg[k] <= xpay_reg[k-1];
                xrem_reg[k] <= xrem_next[k];
                xdq_reg[k]  <= xdq_next[k];
            end
        end
        if (out_load) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: design/dpb_checker.sv
`timescale 1ns / 1ps
`include "depth_pixel_backprojection_core_macros.svh"
module dpb_checker #(
    parameter int  FRAC_BITS   = dpb_pkg::FRAC_BITS_DEF,
    parameter int  COORD_BITS  = dpb_pkg::COORD_BITS_DEF,
    localparam int Z_BITS      = COORD_BITS + FRAC_BITS,
    localparam int OUT_W       = 3 * Z_BITS + 2 + 3 * dpb_pkg::COLOR_W,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    // point_x, point_y, point_z, blue_out, green_out, red_out, zero pad
    input logic [OUT_TDATA_W-1:0] m_tdata
);
    import dpb_pkg::*;

    localparam int XY_W = Z_BITS + 1;

    logic [XY_W-1:0]   pt_x;
    logic [XY_W-1:0]   pt_y;
    logic [Z_BITS-1:0] pt_z;

    assign pt_x = m_tdata[XY_W-1:0];
    assign pt_y = m_tdata[XY_W +: XY_W];
    assign pt_z = m_tdata[2 * XY_W +: Z_BITS];

    `DPB_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output word changed while stalled")
    `DPB_ASSERT(a_in_ready, (!m_tvalid || m_tready) |-> s_tready, "input stalled with output free")
    `DPB_ASSERT(a_zero_depth_point, m_tvalid && (pt_z == '0) |-> (pt_x == '0) && (pt_y == '0), "nonzero x or y at zero z")
    `DPB_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

bind depth_pixel_backprojection_core dpb_checker #(
    .FRAC_BITS (FRAC_BITS),
    .COORD_BITS(COORD_BITS)
) u_dpb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

// File: bench/dpb_point_checker.sv
`timescale 1ns / 1ps
module dpb_point_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dpb_pkg::PADDR_W-1:0]   paddr,
    input  logic [dpb_pkg::PDATA_W-1:0]   pwdata,
    input  logic                          pready,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // raw_depth, pixel_column, pixel_row, blue_in, green_in, red_in
    input  logic [63:0]                   s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // point_x, point_y, point_z, blue_out, green_out, red_out, zero pad
    input  logic [111:0]                  m_tdata,
    output int                            errors,
    output int                            points_checked,
    output int                            points_due
);
    import dpb_pkg::*;

    localparam int Z_BITS  = COORD_BITS_DEF + FRAC_BITS_DEF;
    localparam int XY_BITS = Z_BITS + 1;
    localparam int IN_W    = DEPTH_W + 2 * COORD_BITS_DEF + 3 * COLOR_W;
    localparam int OUT_W   = 3 * Z_BITS + 2 + 3 * COLOR_W;
    localparam longint Z_MAX  = (longint'(1) << Z_BITS) - 1;
    localparam longint XY_MAX = Z_MAX;
    localparam longint XY_MIN = -(longint'(1) << Z_BITS);

    typedef struct packed {
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
        logic [COORD_BITS_DEF-1:0] row;
        logic [COORD_BITS_DEF-1:0] col;
        logic [DEPTH_W-1:0]        depth;
    } pixel_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [Z_BITS-1:0]  z;
        logic [XY_BITS-1:0] y;
        logic [XY_BITS-1:0] x;
    } point_t;

    logic [CFG_W-1:0] depth_scale;
    logic [CFG_W-1:0] center_x;
    logic [CFG_W-1:0] center_y;
    logic [CFG_W-1:0] focal_x;
    logic [CFG_W-1:0] focal_y;

    point_t expected_points[$];
    point_t got;
    point_t want;
    int     err_cnt;
    int     check_cnt;

    assign errors         = err_cnt;
    assign points_checked = check_cnt;

    function automatic logic [XY_BITS-1:0] axis_coord(longint pix, longint ctr, longint foc,
                                                      longint z);
        longint q;
        q = ((pix <<< PIX_FRAC) - ctr) * z / ((foc == 0) ? longint'(1) : foc);
        if (q > XY_MAX) q = XY_MAX;
        if (q < XY_MIN) q = XY_MIN;
        return q[XY_BITS-1:0];
    endfunction

    function automatic point_t project_pixel(pixel_t p);
        point_t pt;
        longint div;
        longint z;
        longint zs;
        div = depth_scale;
        if (div == 0) div = 1;
        z  = (longint'(p.depth) << FRAC_BITS_DEF) / div;
        zs = (z > Z_MAX) ? Z_MAX : z;
        pt.x     = axis_coord(p.col, center_x, focal_x, z);
        pt.y     = axis_coord(p.row, center_y, focal_y, z);
        pt.z     = zs[Z_BITS-1:0];
        pt.blue  = p.blue;
        pt.green = p.green;
        pt.red   = p.red;
        return pt;
    endfunction

    task automatic report_err(input string what);
        if (err_cnt < 30) $display("dpb_point_checker: %0t ns: %s", $time, what);
        err_cnt++;
    endtask

    initial begin
        err_cnt    = 0;
        check_cnt  = 0;
        points_due = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            depth_scale = DEPTH_SCALE_RST;
            center_x    = CENTER_X_RST;
            center_y    = CENTER_Y_RST;
            focal_x     = FOCAL_X_RST;
            focal_y     = FOCAL_Y_RST;
            expected_points.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[PADDR_W-1:2]))
                    REG_DEPTH_SCALE: depth_scale = pwdata[CFG_W-1:0];
                    REG_CENTER_X:    center_x    = pwdata[CFG_W-1:0];
                    REG_CENTER_Y:    center_y    = pwdata[CFG_W-1:0];
                    REG_FOCAL_X:     focal_x     = pwdata[CFG_W-1:0];
                    REG_FOCAL_Y:     focal_y     = pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = point_t'(m_tdata[OUT_W-1:0]);
                if (expected_points.size() == 0) begin
                    report_err($sformatf("unexpected point x=%0d y=%0d z=%0d",
                                         $signed(got.x), $signed(got.y), got.z));
                end else begin
                    want = expected_points.pop_front();
                    check_cnt++;
                    if (got.x !== want.x)
                        report_err($sformatf("point_x %0d, want %0d",
                                             $signed(got.x), $signed(want.x)));
                    if (got.y !== want.y)
                        report_err($sformatf("point_y %0d, want %0d",
                                             $signed(got.y), $signed(want.y)));
                    if (got.z !== want.z)
                        report_err($sformatf("point_z %0d, want %0d", got.z, want.z));
                    if (got.blue !== want.blue)
                        report_err($sformatf("blue_out %0h, want %0h", got.blue, want.blue));
                    if (got.green !== want.green)
                        report_err($sformatf("green_out %0h, want %0h", got.green, want.green));
                    if (got.red !== want.red)
                        report_err($sformatf("red_out %0h, want %0h", got.red, want.red));
                end
            end
            // drop zero-depth pixels, they yield no point
            if (s_tvalid && s_tready && (s_tdata[DEPTH_W-1:0] != '0))
                expected_points.insert(expected_points.size(),
                                       project_pixel(pixel_t'(s_tdata[IN_W-1:0])));
        end
        points_due <= expected_points.size();
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import dpb_pkg::*;

    localparam int LAT_SLACK   = 2 * FRAC_BITS_DEF + COORD_BITS_DEF + 20 + 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 100;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_tvalid;
    logic               s_tready;
    // raw_depth, pixel_column, pixel_row, blue_in, green_in, red_in
    logic [63:0]        s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    // point_x, point_y, point_z, blue_out, green_out, red_out, zero pad
    logic [111:0]       m_tdata;

    int errors;
    int points_checked;
    int points_due;
    int idle_pct;
    int stall_pct;
    int cycle_cnt;
    int pixels_sent;
    int no_depth_cnt;
    int settings_cnt;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    depth_pixel_backprojection_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dpb_point_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .errors         (errors),
        .points_checked (points_checked),
        .points_due     (points_due)
    );

    initial m_tready <= 1'b1;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial cycle_cnt = 0;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycle_cnt);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic send_pixel(input logic [15:0] depth, input logic [11:0] col,
                              input logic [11:0] row, input logic [7:0] blue,
                              input logic [7:0] green, input logic [7:0] red);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {red, green, blue, row, col, depth};
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        if (depth == '0) no_depth_cnt++;
    endtask

    // hold the input until every point is out, then let zero-depth words flush
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (points_due != 0) @(posedge aclk);
        repeat (LAT_SLACK) @(posedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [15:0] scale, input logic [15:0] cx,
                                 input logic [15:0] cy, input logic [15:0] fx,
                                 input logic [15:0] fy);
        drain();
        apb_write(REG_DEPTH_SCALE, scale);
        apb_write(REG_CENTER_X, cx);
        apb_write(REG_CENTER_Y, cy);
        apb_write(REG_FOCAL_X, fx);
        apb_write(REG_FOCAL_Y, fy);
        settings_cnt++;
    endtask

    function automatic logic [15:0] corner_cfg();
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    initial begin
        logic [15:0] depth;
        int          mode;

        aresetn      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        idle_pct     = 0;
        stall_pct    = 0;
        pixels_sent  = 0;
        no_depth_cnt = 0;
        settings_cnt = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_pixel(16'd0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00);
        send_pixel(16'd0, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(16'd1, 12'd0, 12'd0, 8'hFF, 8'h00, 8'hFF);
        send_pixel(16'hFFFF, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(16'hFFFF, 12'd0, 12'd0, 8'h00, 8'hFF, 8'h00);
        send_pixel(16'd1000, 12'd325, 12'd253, 8'h12, 8'h34, 8'h56);
        send_pixel(16'd1000, 12'd326, 12'd254, 8'h9A, 8'hBC, 8'hDE);
        send_pixel(16'h8000, 12'h800, 12'h800, 8'h55, 8'hAA, 8'h0F);
        send_pixel(16'hFFFF, 12'hFFF, 12'd0, 8'hA5, 8'h5A, 8'hF0);
        send_pixel(16'h7FFF, 12'h7FF, 12'h7FF, 8'h80, 8'h01, 8'h7F);

        apply_setting(16'd1, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF);
        send_pixel(16'hFFFF, 12'hFFF, 12'd0, 8'h11, 8'h22, 8'h33);
        send_pixel(16'd1, 12'd0, 12'hFFF, 8'h44, 8'h55, 8'h66);
        send_pixel(16'd4095, 12'hFFF, 12'hFFF, 8'h77, 8'h88, 8'h99);
        send_pixel(16'd4096, 12'd0, 12'd0, 8'hAA, 8'hBB, 8'hCC);

        apply_setting(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd1);
        send_pixel(16'hFFFF, 12'hFFF, 12'hFFF, 8'hDD, 8'hEE, 8'hFF);
        send_pixel(16'd1, 12'hFFF, 12'd0, 8'h01, 8'h02, 8'h04);
        send_pixel(16'd2, 12'd0, 12'd1, 8'h08, 8'h10, 8'h20);
        send_pixel(16'd0, 12'd1, 12'd1, 8'h40, 8'h80, 8'h00);

        apply_setting(16'hFFFF, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 12'h800, 12'h800, 8'hC3, 8'h3C, 8'h99);
        send_pixel(16'hFFFF, 12'd0, 12'hFFF, 8'h66, 8'hE7, 8'h18);
        send_pixel(16'd1, 12'hFFF, 12'hFFF, 8'h81, 8'h42, 8'h24);
        send_pixel(16'hFFFE, 12'h7FF, 12'h801, 8'hFE, 8'h7E, 8'hEF);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: apply_setting(DEPTH_SCALE_RST, CENTER_X_RST, CENTER_Y_RST,
                                 FOCAL_X_RST, FOCAL_Y_RST);
                1: apply_setting(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                 16'($urandom_range(65535)));
                2: apply_setting(16'($urandom_range(5000, 200)), 16'($urandom_range(40000)),
                                 16'($urandom_range(40000)), 16'($urandom_range(65535, 2000)),
                                 16'($urandom_range(65535, 2000)));
                default: apply_setting(corner_cfg(), corner_cfg(), corner_cfg(),
                                       corner_cfg(), corner_cfg());
            endcase
            mode = (ph + ph / 4) % 4;
            idle_pct  = (mode == 1) ? 45 : (mode == 3) ? 28 : 0;
            stall_pct = (mode == 2) ? 45 : (mode == 3) ? 28 : 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 6 && k == PHASE_ITEMS / 2) drain();
                case ($urandom_range(7))
                    0:       depth = 16'd0;
                    1, 2:    depth = 16'($urandom_range(255, 1));
                    default: depth = 16'($urandom_range(65535));
                endcase
                send_pixel(depth, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                           8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)));
            end
        end
        drain();

        $display("tb_top: %0d pixels sent (%0d without depth), %0d points checked, %0d settings",
                 pixels_sent, no_depth_cnt, points_checked, settings_cnt);
        $display("tb_top: zero, unit and full-scale divisors and centers; gaps and stalls to 45%%");
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
